### hw/rtl/kli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and constants of the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int FIELD_W     = 24;  // width of every pose field on the ports
    localparam int MODE_W      = 2;
    localparam int STEPS_W     = 8;
    localparam int KEYS_OUT_W  = 4;
    localparam int WIDE_W      = 34;  // holds any sum of two pose values, sign included
    localparam int LANES       = 4;   // x, y, z, angle

    localparam int MAX_KEYS_DEF = 9;
    localparam int VALUE_W_DEF  = 24;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd60;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_SAVE = 2'd1,
        MODE_PLAY = 2'd2,
        MODE_SET  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_A,
        S_RD_B,
        S_CAP_B,
        S_DIV,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic set_pose;
        logic save;
        logic play_start;
        logic play_stop;
        logic tick_step;
        logic tick_adv;
        logic tick_end;
        logic rd_b;
        logic cap_a;
        logic cap_b;
        logic load_key0;
        logic div_start;
        logic load_delta;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  active;
        logic  seg_done;
        logic  last_seg;
        logic  can_play;
        logic  div_done;
        logic  out_free;
    } t_status;

endpackage

### hw/rtl/kli_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_item_if / kli_result_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface kli_item_if;
    logic                                 valid;
    logic                                 ready;
    logic        [kli_pkg::MODE_W-1:0]    mode;
    logic signed [kli_pkg::FIELD_W-1:0]   in_x;
    logic signed [kli_pkg::FIELD_W-1:0]   in_y;
    logic signed [kli_pkg::FIELD_W-1:0]   in_z;
    logic signed [kli_pkg::FIELD_W-1:0]   in_angle;

    modport source (output valid, mode, in_x, in_y, in_z, in_angle, input ready);
    modport sink   (input valid, mode, in_x, in_y, in_z, in_angle, output ready);
endinterface

interface kli_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [kli_pkg::FIELD_W-1:0]    cur_x;
    logic signed [kli_pkg::FIELD_W-1:0]    cur_y;
    logic signed [kli_pkg::FIELD_W-1:0]    cur_z;
    logic signed [kli_pkg::FIELD_W-1:0]    cur_angle;
    logic                                  is_playing;
    logic                                  finished;
    logic        [kli_pkg::KEYS_OUT_W-1:0] stored_keys;
    logic                                  save_refused;

    modport source (output valid, cur_x, cur_y, cur_z, cur_angle, is_playing, finished,
                    stored_keys, save_refused, input ready);
    modport sink   (input valid, cur_x, cur_y, cur_z, cur_angle, is_playing, finished,
                    stored_keys, save_refused, output ready);
endinterface

### hw/rtl/keyframe_linear_interpolator_unit.sv
`timescale 1ns / 1ps
// Flow: set, save, stop and plain ticks go from decode straight to the result hand-off;
//   play and segment-change ticks first read two keys and run the divider lanes.
// A new word is accepted only in the idle state, once the result of the last word is
//   handed off; recomputing increments waits on the one-bit-per-cycle divider lanes.
// Reset: synchronous, active low; clears pose, increments, key count and playback state,
//   reloads steps_per_segment to 60. Key store contents are not cleared.
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit
// Keyframe player: stores poses and steps linearly between them on each tick.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit #(
    parameter int MAX_KEYS    = kli_pkg::MAX_KEYS_DEF,
    parameter int VALUE_WIDTH = kli_pkg::VALUE_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kli_item_if.sink                      i_item,
    kli_result_if.source                  o_result,
    input  logic                          i_cfg_we,
    input  logic [kli_pkg::STEPS_W-1:0]   i_cfg_data
);

    kli_pkg::t_cmd    cmd;
    kli_pkg::t_status status;
    logic             in_ready;

    kli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_item.ready = in_ready;

    kli_dp #(
        .MAX_KEYS    (MAX_KEYS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_item.mode),
        .i_in_x         (i_item.in_x),
        .i_in_y         (i_item.in_y),
        .i_in_z         (i_item.in_z),
        .i_in_angle     (i_item.in_angle),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_cur_x        (o_result.cur_x),
        .o_cur_y        (o_result.cur_y),
        .o_cur_z        (o_result.cur_z),
        .o_cur_angle    (o_result.cur_angle),
        .o_is_playing   (o_result.is_playing),
        .o_finished     (o_result.finished),
        .o_stored_keys  (o_result.stored_keys),
        .o_save_refused (o_result.save_refused)
    );

endmodule

### hw/rtl/kli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kli_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/kli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_div
// Serial restoring divider: (b - a) / divisor, truncated toward zero,
// saturated to VALUE_WIDTH signed. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module kli_div #(
    parameter int VALUE_WIDTH = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [VALUE_WIDTH-1:0]      i_a,
    input  logic signed [VALUE_WIDTH-1:0]      i_b,
    input  logic [kli_pkg::STEPS_W-1:0]        i_divisor,
    output logic                               o_done,
    output logic signed [VALUE_WIDTH-1:0]      o_quot
);

    localparam int QW = VALUE_WIDTH + 1;
    localparam int CW = $clog2(QW + 1);
    localparam int DW = kli_pkg::STEPS_W;
    localparam logic [QW-1:0] POS_LIM = QW'((longint'(1) << (VALUE_WIDTH - 1)) - 1);
    localparam logic [QW-1:0] NEG_LIM = QW'(longint'(1) << (VALUE_WIDTH - 1));

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [QW-1:0]     r_quo, n_quo;
    logic [DW-1:0]     r_rem, n_rem;
    logic [DW-1:0]     r_dvs, n_dvs;
    logic              r_neg, n_neg;

    logic signed [QW-1:0] diff;
    logic [DW:0]          trial;

    always_comb begin
        diff  = QW'(i_b) - QW'(i_a);
        trial = {r_rem, r_quo[QW-1]};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_neg  = r_neg;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_neg  = diff[QW-1];
            n_quo  = diff[QW-1] ? QW'(-diff) : QW'(diff);
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DW'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = trial[DW-1:0];
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_quo > POS_LIM) ? POS_LIM[VALUE_WIDTH-1:0] : r_quo[VALUE_WIDTH-1:0];
        end else if (r_quo > NEG_LIM) begin
            o_quot = NEG_LIM[VALUE_WIDTH-1:0];
        end else begin
            o_quot = VALUE_WIDTH'(-r_quo);
        end
    end

    assign o_done = r_done;

endmodule

### hw/rtl/kli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_ctrl
// Sequencer: decodes each word and steps the datapath through reads of the
// key store, the increment division and the result hand-off.
// ----------------------------------------------------------------------------
module kli_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  kli_pkg::t_status i_status,
    output kli_pkg::t_cmd    o_cmd
);

    kli_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kli_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        case (r_state)
            kli_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = kli_pkg::S_DECODE;
                end
            end
            kli_pkg::S_DECODE: begin
                n_state = kli_pkg::S_EMIT;
                case (i_status.mode)
                    kli_pkg::MODE_TICK: begin
                        if (i_status.active) begin
                            if (!i_status.seg_done) begin
                                o_cmd.tick_step = 1'b1;
                            end else if (i_status.last_seg) begin
                                o_cmd.tick_end = 1'b1;
                            end else begin
                                o_cmd.tick_adv = 1'b1;
                                n_state        = kli_pkg::S_RD_A;
                            end
                        end
                    end
                    kli_pkg::MODE_SAVE: begin
                        o_cmd.save = 1'b1;
                    end
                    kli_pkg::MODE_PLAY: begin
                        if (i_status.can_play) begin
                            o_cmd.play_start = 1'b1;
                            n_state          = kli_pkg::S_RD_A;
                        end else begin
                            o_cmd.play_stop = 1'b1;
                        end
                    end
                    kli_pkg::MODE_SET: begin
                        o_cmd.set_pose = 1'b1;
                    end
                    default: begin
                        n_state = kli_pkg::S_EMIT;
                    end
                endcase
            end
            kli_pkg::S_RD_A: begin
                n_state = kli_pkg::S_RD_B;
            end
            kli_pkg::S_RD_B: begin
                o_cmd.rd_b  = 1'b1;
                o_cmd.cap_a = 1'b1;
                n_state     = kli_pkg::S_CAP_B;
            end
            kli_pkg::S_CAP_B: begin
                o_cmd.cap_b     = 1'b1;
                o_cmd.load_key0 = (i_status.mode == kli_pkg::MODE_PLAY);
                n_state         = kli_pkg::S_DIV;
            end
            kli_pkg::S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = kli_pkg::S_WAIT;
            end
            kli_pkg::S_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.load_delta = 1'b1;
                    n_state          = kli_pkg::S_EMIT;
                end
            end
            kli_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = kli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kli_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/kli_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_dp
// Datapath: pose and increment registers, key store, four divider lanes,
// playback counters and the result register.
// ----------------------------------------------------------------------------
module kli_dp #(
    parameter int MAX_KEYS    = 9,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kli_pkg::t_cmd                        i_cmd,
    output kli_pkg::t_status                     o_status,
    input  logic                                 i_cfg_we,
    input  logic        [kli_pkg::STEPS_W-1:0]   i_cfg_data,
    input  logic        [kli_pkg::MODE_W-1:0]    i_mode,
    input  logic signed [kli_pkg::FIELD_W-1:0]   i_in_x,
    input  logic signed [kli_pkg::FIELD_W-1:0]   i_in_y,
    input  logic signed [kli_pkg::FIELD_W-1:0]   i_in_z,
    input  logic signed [kli_pkg::FIELD_W-1:0]   i_in_angle,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [kli_pkg::FIELD_W-1:0]   o_cur_x,
    output logic signed [kli_pkg::FIELD_W-1:0]   o_cur_y,
    output logic signed [kli_pkg::FIELD_W-1:0]   o_cur_z,
    output logic signed [kli_pkg::FIELD_W-1:0]   o_cur_angle,
    output logic                                 o_is_playing,
    output logic                                 o_finished,
    output logic        [kli_pkg::KEYS_OUT_W-1:0] o_stored_keys,
    output logic                                 o_save_refused
);

    localparam int WW    = kli_pkg::WIDE_W;
    localparam int FW    = kli_pkg::FIELD_W;
    localparam int SW    = kli_pkg::STEPS_W;
    localparam int NL    = kli_pkg::LANES;
    localparam int KW    = $clog2(MAX_KEYS + 1);
    localparam int AW    = $clog2(MAX_KEYS);
    localparam int KEY_W = NL * VALUE_WIDTH;

    localparam logic signed [WW-1:0] VW_MAX  = WW'((longint'(1) << (VALUE_WIDTH - 1)) - 1);
    localparam logic signed [WW-1:0] VW_MIN  = WW'(-(longint'(1) << (VALUE_WIDTH - 1)));
    localparam logic signed [WW-1:0] OUT_MAX = WW'((longint'(1) << (FW - 1)) - 1);
    localparam logic signed [WW-1:0] OUT_MIN = WW'(-(longint'(1) << (FW - 1)));

    function automatic logic signed [VALUE_WIDTH-1:0] sat_vw(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] s;
        s = (v > VW_MAX) ? VW_MAX : ((v < VW_MIN) ? VW_MIN : v);
        return s[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic signed [FW-1:0] sat_out(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] s;
        s = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
        return s[FW-1:0];
    endfunction

    logic        [SW-1:0]          r_steps;
    kli_pkg::t_mode                r_mode;
    logic signed [FW-1:0]          r_in    [NL];
    logic signed [VALUE_WIDTH-1:0] r_pose  [NL];
    logic signed [VALUE_WIDTH-1:0] r_delta [NL];
    logic        [KEY_W-1:0]       r_key_a;
    logic        [KEY_W-1:0]       r_key_b;
    logic        [KW-1:0]          r_total;
    logic        [KW-1:0]          r_seg;
    logic        [SW-1:0]          r_cnt;
    logic                          r_active;
    logic                          r_fin;
    logic                          r_ref;

    logic                          r_out_valid;
    logic signed [FW-1:0]          r_out_cur [NL];
    logic                          r_out_play;
    logic                          r_out_fin;
    logic        [kli_pkg::KEYS_OUT_W-1:0] r_out_keys;
    logic                          r_out_ref;

    logic        [SW-1:0]          steps_eff;
    logic        [KW-1:0]          seg_nxt;
    logic        [KW+1:0]          seg_end;
    logic                          store_full;
    logic        [KEY_W-1:0]       wdata;
    logic        [KEY_W-1:0]       rdata;
    logic        [AW-1:0]          raddr;
    logic        [KW-1:0]          raddr_full;
    logic        [NL-1:0]          div_done;
    logic signed [VALUE_WIDTH-1:0] div_quot [NL];
    logic        [KW+kli_pkg::KEYS_OUT_W-1:0] keys_ext;

    assign steps_eff  = (r_steps == '0) ? SW'(1) : r_steps;
    assign seg_nxt    = r_seg + KW'(1);
    assign seg_end    = (KW + 2)'(seg_nxt) + (KW + 2)'(2);
    assign store_full = (r_total == KW'(MAX_KEYS));
    assign raddr_full = i_cmd.rd_b ? seg_nxt : r_seg;
    assign raddr      = raddr_full[AW-1:0];
    assign keys_ext   = (KW + kli_pkg::KEYS_OUT_W)'(r_total);

    always_comb begin
        o_status          = '0;
        o_status.mode     = r_mode;
        o_status.active   = r_active;
        o_status.seg_done = (r_cnt >= steps_eff);
        o_status.last_seg = (seg_end > (KW + 2)'(r_total));
        o_status.can_play = !r_active && (r_total > KW'(1));
        o_status.div_done = &div_done;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    // key word layout: lane 0 (x) in the low bits
    generate
        for (genvar g = 0; g < NL; g++) begin : g_lane
            assign wdata[g*VALUE_WIDTH +: VALUE_WIDTH] = r_pose[g];

            kli_div #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_div (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_start   (i_cmd.div_start),
                .i_a       ($signed(r_key_a[g*VALUE_WIDTH +: VALUE_WIDTH])),
                .i_b       ($signed(r_key_b[g*VALUE_WIDTH +: VALUE_WIDTH])),
                .i_divisor (steps_eff),
                .o_done    (div_done[g]),
                .o_quot    (div_quot[g])
            );
        end
    endgenerate

    kli_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAX_KEYS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.save && !store_full),
        .i_waddr (r_total[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps  <= kli_pkg::STEPS_RESET;
            r_total  <= '0;
            r_seg    <= '0;
            r_cnt    <= '0;
            r_active <= 1'b0;
            r_fin    <= 1'b0;
            r_ref    <= 1'b0;
            r_mode   <= kli_pkg::MODE_TICK;
            for (int i = 0; i < NL; i++) begin
                r_pose[i]  <= '0;
                r_delta[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_steps <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_mode <= kli_pkg::t_mode'(i_mode);
                r_fin  <= 1'b0;
                r_ref  <= 1'b0;
            end
            if (i_cmd.save) begin
                if (store_full) begin
                    r_ref <= 1'b1;
                end else begin
                    r_total <= r_total + KW'(1);
                end
            end
            if (i_cmd.play_start) begin
                r_active <= 1'b1;
                r_seg    <= '0;
                r_cnt    <= '0;
            end
            if (i_cmd.play_stop) begin
                r_active <= 1'b0;
            end
            if (i_cmd.tick_step) begin
                r_cnt <= r_cnt + SW'(1);
            end
            if (i_cmd.tick_adv) begin
                r_seg <= seg_nxt;
                r_cnt <= '0;
            end
            if (i_cmd.tick_end) begin
                r_seg    <= '0;
                r_active <= 1'b0;
                r_fin    <= 1'b1;
            end
            for (int i = 0; i < NL; i++) begin
                if (i_cmd.set_pose) begin
                    r_pose[i] <= sat_vw(WW'(r_in[i]));
                end else if (i_cmd.load_key0) begin
                    r_pose[i] <= $signed(r_key_a[i*VALUE_WIDTH +: VALUE_WIDTH]);
                end else if (i_cmd.tick_step) begin
                    r_pose[i] <= sat_vw(WW'(r_pose[i]) + WW'(r_delta[i]));
                end
                if (i_cmd.load_delta) begin
                    r_delta[i] <= div_quot[i];
                end
            end
        end
    end

    // payload captures
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in[0] <= i_in_x;
            r_in[1] <= i_in_y;
            r_in[2] <= i_in_z;
            r_in[3] <= i_in_angle;
        end
        if (i_cmd.cap_a) begin
            r_key_a <= rdata;
        end
        if (i_cmd.cap_b) begin
            r_key_b <= rdata;
        end
        if (i_cmd.emit) begin
            for (int i = 0; i < NL; i++) begin
                r_out_cur[i] <= sat_out(WW'(r_pose[i]));
            end
            r_out_play <= r_active;
            r_out_fin  <= r_fin;
            r_out_keys <= keys_ext[kli_pkg::KEYS_OUT_W-1:0];
            r_out_ref  <= r_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cur_x        = r_out_cur[0];
    assign o_cur_y        = r_out_cur[1];
    assign o_cur_z        = r_out_cur[2];
    assign o_cur_angle    = r_out_cur[3];
    assign o_is_playing   = r_out_play;
    assign o_finished     = r_out_fin;
    assign o_stored_keys  = r_out_keys;
    assign o_save_refused = r_out_ref;

endmodule
